>>> src/oel_pkg.sv
// ----------------------------------------------------------------------------
// Ordered entry list package
// Shared types, codes and sizing constants for the ordered entry list block.
// ----------------------------------------------------------------------------
package oel_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int MODE_W  = 2;
    localparam int ID_W    = 16;
    localparam int TICK_W  = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_NOP    = 2'd3
    } oel_mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } oel_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } oel_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   entry_id;
        logic [TICK_W-1:0] entry_tick;
        logic [POS_W-1:0]  position;
    } oel_in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   found_position;
        logic [ID_W-1:0]    head_id;
        logic [TICK_W-1:0]  head_tick;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } oel_out_item_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic append;
        logic remove;
        logic match_load;
        logic match_shift;
    } oel_cell_cmd_t;

endpackage

>>> src/oel_in_if.sv
// ----------------------------------------------------------------------------
// Ordered entry list input channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface oel_in_if;
    logic                 valid;
    logic                 ready;
    oel_pkg::oel_in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/oel_out_if.sv
// ----------------------------------------------------------------------------
// Ordered entry list output channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface oel_out_if;
    logic                  valid;
    logic                  ready;
    oel_pkg::oel_out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/ordered_entry_list_with_search.sv
// ----------------------------------------------------------------------------
// Ordered entry list with search
// Ordered list of up to DEPTH (id, tick) entries with append, delete at a
// 1-based position, and find by id.
// ----------------------------------------------------------------------------
// Each transaction takes one command. Append and delete do their work in the
// accepting cycle (the chain of cells writes the tail or shifts left in
// parallel), and the result is registered from ST_RESULT once the output
// register is free. Find loads a match flag in every cell, then shifts the
// flags toward the head one cell per cycle until the head flag is set or the
// held entries are exhausted, and then registers its result the same way. A
// new command is taken while the previous result still waits in the output
// register.
module ordered_entry_list_with_search #(
    parameter int DEPTH = oel_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    oel_in_if.sink    in_ch,
    oel_out_if.source out_ch
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);
    localparam int CMP_W  = ((CNT_W > oel_pkg::POS_W) ? CNT_W : oel_pkg::POS_W) + 1;

    oel_pkg::oel_state_t    state_reg,   state_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [STEP_W-1:0]      step_reg,    step_next;
    oel_pkg::oel_status_t   status_reg,  status_next;
    logic [oel_pkg::POS_W-1:0] found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;
    oel_pkg::oel_out_item_t out_data_reg,  out_data_next;

    oel_pkg::oel_cell_cmd_t cmd;
    logic                   accept;
    logic                   list_full;
    logic                   pos_bad;
    logic                   last_step;

    logic [oel_pkg::ID_W-1:0]   cell_id   [DEPTH];
    logic [oel_pkg::TICK_W-1:0] cell_tick [DEPTH];
    logic [DEPTH-1:0]           cell_match;

    assign in_ch.ready = (state_reg == oel_pkg::ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign list_full   = (count_reg == CNT_W'(DEPTH));
    assign pos_bad     = (in_ch.data.position == '0) ||
                         (CMP_W'(in_ch.data.position) > CMP_W'(count_reg));
    assign last_step   = ((CNT_W'(step_reg) + CNT_W'(1)) >= count_reg);

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [oel_pkg::ID_W-1:0]   nbr_id;
        logic [oel_pkg::TICK_W-1:0] nbr_tick;
        logic                       nbr_match;

        if (g == DEPTH - 1)
        begin : g_last
            assign nbr_id    = '0;
            assign nbr_tick  = '0;
            assign nbr_match = 1'b0;
        end
        else
        begin : g_mid
            assign nbr_id    = cell_id[g+1];
            assign nbr_tick  = cell_tick[g+1];
            assign nbr_match = cell_match[g+1];
        end

        oel_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .count     (count_reg),
            .position  (in_ch.data.position),
            .key_id    (in_ch.data.entry_id),
            .key_tick  (in_ch.data.entry_tick),
            .nbr_id    (nbr_id),
            .nbr_tick  (nbr_tick),
            .nbr_match (nbr_match),
            .id        (cell_id[g]),
            .tick      (cell_tick[g]),
            .match     (cell_match[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd            = '0;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            oel_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = oel_pkg::STAT_OK;
                    found_next  = '0;
                    step_next   = '0;
                    state_next  = oel_pkg::ST_RESULT;
                    case (oel_pkg::oel_mode_t'(in_ch.data.mode))
                        oel_pkg::MODE_APPEND:
                        begin
                            if (list_full)
                                status_next = oel_pkg::STAT_FULL;
                            else
                            begin
                                cmd.append = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        oel_pkg::MODE_DELETE:
                        begin
                            if (count_reg == '0)
                                status_next = oel_pkg::STAT_EMPTY;
                            else if (pos_bad)
                                status_next = oel_pkg::STAT_RANGE;
                            else
                            begin
                                cmd.remove = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        oel_pkg::MODE_FIND:
                        begin
                            cmd.match_load = 1'b1;
                            state_next     = oel_pkg::ST_SEARCH;
                        end
                        default:
                        begin
                            status_next = oel_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            oel_pkg::ST_SEARCH:
            begin
                if (cell_match[0])
                begin
                    found_next = oel_pkg::POS_W'(CNT_W'(step_reg) + CNT_W'(1));
                    state_next = oel_pkg::ST_RESULT;
                end
                else if (last_step)
                begin
                    status_next = oel_pkg::STAT_NOTFOUND;
                    state_next  = oel_pkg::ST_RESULT;
                end
                else
                begin
                    // advance: pull flags one cell toward the head
                    cmd.match_shift = 1'b1;
                    step_next       = step_reg + STEP_W'(1);
                end
            end
            oel_pkg::ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = status_reg;
                    out_data_next.found_position = found_reg;
                    out_data_next.is_empty       = (count_reg == '0);
                    out_data_next.entry_count    = oel_pkg::COUNT_W'(count_reg);
                    if (count_reg == '0)
                    begin
                        out_data_next.head_id   = '0;
                        out_data_next.head_tick = '0;
                    end
                    else
                    begin
                        out_data_next.head_id   = cell_id[0];
                        out_data_next.head_tick = cell_tick[0];
                    end
                    state_next = oel_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oel_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oel_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            status_reg    <= oel_pkg::STAT_OK;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

>>> src/oel_cell.sv
// ----------------------------------------------------------------------------
// Ordered entry list cell
// Holds one list slot and a search flag; takes data from its right neighbor
// on delete and passes its flag to the left neighbor during a search.
// ----------------------------------------------------------------------------
module oel_cell #(
    parameter int IDX     = 0,
    parameter int CNT_W   = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  oel_pkg::oel_cell_cmd_t      cmd,
    input  logic [CNT_W-1:0]            count,
    input  logic [oel_pkg::POS_W-1:0]   position,
    input  logic [oel_pkg::ID_W-1:0]    key_id,
    input  logic [oel_pkg::TICK_W-1:0]  key_tick,
    input  logic [oel_pkg::ID_W-1:0]    nbr_id,
    input  logic [oel_pkg::TICK_W-1:0]  nbr_tick,
    input  logic                        nbr_match,
    output logic [oel_pkg::ID_W-1:0]    id,
    output logic [oel_pkg::TICK_W-1:0]  tick,
    output logic                        match
);

    localparam int CMP_W = ((CNT_W > oel_pkg::POS_W) ? CNT_W : oel_pkg::POS_W) + 1;

    logic [oel_pkg::ID_W-1:0]   id_reg;
    logic [oel_pkg::TICK_W-1:0] tick_reg;
    logic                       match_reg;
    logic                       match_next;
    logic                       is_tail;
    logic                       in_list;
    logic                       at_or_after_gap;

    assign is_tail         = (CNT_W'(IDX) == count);
    assign in_list         = (CNT_W'(IDX) < count);
    assign at_or_after_gap = (CMP_W'(IDX + 1) >= CMP_W'(position));

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (cmd.append && is_tail)
        begin
            id_reg   <= key_id;
            tick_reg <= key_tick;
        end
        else if (cmd.remove && at_or_after_gap)
        begin
            // close the gap: take the neighbor's entry
            id_reg   <= nbr_id;
            tick_reg <= nbr_tick;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (cmd.match_load)
            match_next = in_list && (id_reg == key_id);
        else if (cmd.match_shift)
            match_next = nbr_match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign id    = id_reg;
    assign tick  = tick_reg;
    assign match = match_reg;

endmodule

>>> sim/ordered_entry_list_with_search_tb.sv
// ----------------------------------------------------------------------------
// Ordered entry list with search testbench
// Sends append, delete, find and unused-mode commands through the input
// channel, predicts each result from a local copy of the list, and checks
// every result field in order. Traffic runs under several idle and stall
// mixes, with one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module ordered_entry_list_with_search_tb;

    localparam int LIST_DEPTH     = oel_pkg::DEPTH_DEFAULT;
    localparam int IDX_W          = $clog2(LIST_DEPTH);
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int MAX_GAP        = 60;
    localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 8;
    localparam int MAX_REPORTS    = 10;
    localparam int RX_HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    oel_in_if  in_ch();
    oel_out_if out_ch();

    ordered_entry_list_with_search #(
        .DEPTH (LIST_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Local copy of the list
    logic [oel_pkg::ID_W-1:0]   list_ids   [LIST_DEPTH];
    logic [oel_pkg::TICK_W-1:0] list_ticks [LIST_DEPTH];
    int                         list_count = 0;

    oel_pkg::oel_out_item_t pending_results[$];

    int   fail_count         = 0;
    int   cycle_count        = 0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic rx_hold            = 1'b0;
    event rx_hold_go;

    function automatic oel_pkg::oel_out_item_t apply_command(input oel_pkg::oel_in_item_t cmd);
        oel_pkg::oel_out_item_t res;
        int                     found;
        found = 0;
        res = '0;
        res.status = oel_pkg::STAT_OK;
        case (oel_pkg::oel_mode_t'(cmd.mode))
            oel_pkg::MODE_APPEND:
            begin
                if (list_count >= LIST_DEPTH)
                    res.status = oel_pkg::STAT_FULL;
                else
                begin
                    list_ids[IDX_W'(list_count)]   = cmd.entry_id;
                    list_ticks[IDX_W'(list_count)] = cmd.entry_tick;
                    list_count++;
                end
            end
            oel_pkg::MODE_DELETE:
            begin
                if (list_count == 0)
                    res.status = oel_pkg::STAT_EMPTY;
                else if (cmd.position == 0 || cmd.position > list_count)
                    res.status = oel_pkg::STAT_RANGE;
                else
                begin
                    // close the gap toward the head
                    for (int i = cmd.position - 1; i < list_count - 1; i++)
                    begin
                        list_ids[IDX_W'(i)]   = list_ids[IDX_W'(i + 1)];
                        list_ticks[IDX_W'(i)] = list_ticks[IDX_W'(i + 1)];
                    end
                    list_count--;
                end
            end
            oel_pkg::MODE_FIND:
            begin
                for (int i = 0; i < list_count && found == 0; i++)
                begin
                    if (list_ids[IDX_W'(i)] == cmd.entry_id)
                        found = i + 1;
                end
                if (found == 0)
                    res.status = oel_pkg::STAT_NOTFOUND;
            end
            default: ;
        endcase
        res.found_position = found[oel_pkg::POS_W-1:0];
        if (list_count > 0)
        begin
            res.head_id   = list_ids[0];
            res.head_tick = list_ticks[0];
            res.is_empty  = 1'b0;
        end
        else
        begin
            res.head_id   = '0;
            res.head_tick = '0;
            res.is_empty  = 1'b1;
        end
        res.entry_count = list_count[oel_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic oel_pkg::oel_in_item_t make_command(
        input oel_pkg::oel_mode_t           mode,
        input logic [oel_pkg::ID_W-1:0]     id,
        input logic [oel_pkg::TICK_W-1:0]   tick,
        input logic [oel_pkg::POS_W-1:0]    pos);
        oel_pkg::oel_in_item_t cmd;
        cmd.mode       = mode;
        cmd.entry_id   = id;
        cmd.entry_tick = tick;
        cmd.position   = pos;
        return cmd;
    endfunction

    // Mostly meaningful commands: positions inside the list, ids from a
    // small pool so that finds hit and duplicates occur
    function automatic oel_pkg::oel_in_item_t make_random_command(input int append_pct);
        oel_pkg::oel_in_item_t cmd;
        int                    r;
        cmd.mode       = oel_pkg::MODE_NOP;
        cmd.entry_id   = oel_pkg::ID_W'($urandom);
        cmd.entry_tick = $urandom;
        cmd.position   = oel_pkg::POS_W'($urandom_range(31));
        if ($urandom_range(1) == 0)
            cmd.entry_id = oel_pkg::ID_W'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 4)
            cmd.mode = oel_pkg::MODE_NOP;
        else if ($urandom_range(99) < append_pct)
            cmd.mode = oel_pkg::MODE_APPEND;
        else if ($urandom_range(1) == 0)
        begin
            cmd.mode = oel_pkg::MODE_DELETE;
            if (list_count > 0 && $urandom_range(99) < 80)
                cmd.position = oel_pkg::POS_W'($urandom_range(list_count, 1));
        end
        else
        begin
            cmd.mode = oel_pkg::MODE_FIND;
            if (list_count > 0 && $urandom_range(99) < 70)
                cmd.entry_id = list_ids[IDX_W'($urandom_range(list_count - 1))];
        end
        return cmd;
    endfunction

    task automatic send_command(input oel_pkg::oel_in_item_t cmd);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= cmd;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pending_results.push_back(apply_command(cmd));
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_empty_list();
        send_command(make_command(oel_pkg::MODE_FIND, 16'h1234, 32'h0, 5'd0));
        send_command(make_command(oel_pkg::MODE_DELETE, 16'h0, 32'h0, 5'd1));
        send_command(make_command(oel_pkg::MODE_NOP, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
    endtask

    task automatic test_fill_to_full();
        logic [oel_pkg::ID_W-1:0]   id;
        logic [oel_pkg::TICK_W-1:0] tick;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            id   = 16'h0100 + oel_pkg::ID_W'(k);
            tick = $urandom;
            if (k == 0)
            begin
                id   = '0;
                tick = '0;
            end
            else if (k == LIST_DEPTH - 1)
            begin
                id   = '1;
                tick = '1;
            end
            else if (k == 7)
                id = 16'h0103;
            send_command(make_command(oel_pkg::MODE_APPEND, id, tick, 5'd0));
        end
        send_command(make_command(oel_pkg::MODE_APPEND, 16'hBEEF, 32'h1234_5678, 5'd0));
        send_command(make_command(oel_pkg::MODE_NOP, 16'h0, 32'h0, 5'd0));
    endtask

    task automatic test_delete_edges();
        send_command(make_command(oel_pkg::MODE_DELETE, 16'h0, 32'h0, 5'd0));
        send_command(make_command(oel_pkg::MODE_DELETE, 16'h0, 32'h0, 5'd31));
        send_command(make_command(oel_pkg::MODE_DELETE, 16'h0, 32'h0, 5'(LIST_DEPTH)));
        send_command(make_command(oel_pkg::MODE_DELETE, 16'h0, 32'h0, 5'(LIST_DEPTH)));
        send_command(make_command(oel_pkg::MODE_DELETE, 16'h0, 32'h0, 5'd1));
    endtask

    task automatic test_find_by_id();
        send_command(make_command(oel_pkg::MODE_FIND, 16'h0103, 32'h0, 5'd0));
        send_command(make_command(oel_pkg::MODE_FIND, 16'h010E, 32'h0, 5'd0));
        send_command(make_command(oel_pkg::MODE_FIND, 16'hFFFF, 32'hFFFF_FFFF, 5'd0));
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int append_pct;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        append_pct         = 50;
        for (int n = 0; n < n_items; n++)
        begin
            // sweep the fill level between empty and full
            if (n % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: append_pct = 15;
                    1: append_pct = 50;
                    default: append_pct = 85;
                endcase
            end
            send_command(make_random_command(append_pct));
        end
        wait_for_drain();
    endtask

    task automatic test_output_hold();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        -> rx_hold_go;
        for (int n = 0; n < 40; n++)
            send_command(make_random_command(50));
        wait_for_drain();
    endtask

    // Long receiver hold, counted in cycles
    always
    begin
        @(rx_hold_go);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Receiver: check each accepted result, then pick the next ready
    always @(posedge clk)
    begin
        oel_pkg::oel_out_item_t want;
        oel_pkg::oel_out_item_t got;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got = out_ch.data;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("tb: unexpected result %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status
                    || got.found_position !== want.found_position
                    || got.head_id !== want.head_id
                    || got.head_tick !== want.head_tick
                    || got.is_empty !== want.is_empty
                    || got.entry_count !== want.entry_count)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("tb: mismatch expected %p actual %p", want, got);
                end
            end
        end
        if (rx_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_to_full();
        test_delete_edges();
        test_find_by_id();
        wait_for_drain();

        test_random_traffic(460, 0, 0);
        test_random_traffic(460, 85, 0);
        test_output_hold();
        test_random_traffic(460, 0, 85);
        test_random_traffic(460, 22, 22);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> ordered_entry_list_with_search.f
src/oel_pkg.sv
src/oel_in_if.sv
src/oel_out_if.sv
src/oel_cell.sv
src/ordered_entry_list_with_search.sv
sim/ordered_entry_list_with_search_tb.sv
